// File: hw/rtl/ecd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_pkg: shared types and constants of the calendar date converter
// Sequencer states, operand width and the month length table.
// ----------------------------------------------------------------------------
package ecd_pkg;

	localparam int OP_W = 33;

	// Seconds are biased so that zero falls on 1901-01-01 00:00:00.
	localparam logic [OP_W-1:0] EPOCH_BIAS = 33'd2177452800;
	localparam logic [OP_W-1:0] DAY_SECS   = 33'd86400;
	localparam logic [OP_W-1:0] HOUR_SECS  = 33'd3600;
	localparam logic [OP_W-1:0] MIN_SECS   = 33'd60;
	localparam logic [OP_W-1:0] QUAD_DAYS  = 33'd1461;
	localparam logic [7:0]      BASE_YOFF  = 8'd1;
	localparam logic [3:0]      LAST_MON   = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAYS,
		ST_HOUR,
		ST_MIN,
		ST_QUAD,
		ST_YEAR,
		ST_MON,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic            ge;
		logic [OP_W-1:0] diff;
	} csub_res_t;

	function automatic logic [8:0] year_days(input logic [7:0] yoff);
		return (yoff[1:0] == 2'd0) ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		case (mon)
			4'd1:                      len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// File: hw/rtl/ecd_csub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_csub: shared compare and subtract unit
// Compares the running remainder against an operand and forms the difference.
// ----------------------------------------------------------------------------
module ecd_csub (
	input  logic [ecd_pkg::OP_W-1:0] a,
	input  logic [ecd_pkg::OP_W-1:0] b,
	output ecd_pkg::csub_res_t       res
);
	import ecd_pkg::*;

	logic [OP_W:0] wide;

	assign wide     = {1'b0, a} - {1'b0, b};
	assign res.ge   = ~wide[OP_W];
	assign res.diff = wide[OP_W-1:0];

endmodule

// File: hw/rtl/epoch_seconds_to_calendar_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date: signed epoch seconds to calendar date
// A result strobe follows the beat that starts a conversion; one compare
// and subtract unit steps through day, hour, minute and four-year
// divisions, then years and months. A new beat is taken in the cycle after
// the strobe. The receiver cannot stall.
// Reset returns the sequencer to idle at once; no other state is kept.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] epoch_seconds,
	output logic        done,
	output logic [5:0]  second,
	output logic [5:0]  minute,
	output logic [4:0]  hour,
	output logic [4:0]  day_of_month,
	output logic [3:0]  month,
	output logic [7:0]  year_offset
);
	import ecd_pkg::*;

	state_t          state_q, state_nx;
	logic [OP_W-1:0] rem_q;
	logic [OP_W-1:0] rem_nx;
	logic [15:0]     quo_q;
	logic [15:0]     day_q;
	logic [3:0]      k_q;
	logic [3:0]      mon_q;
	logic [7:0]      year_q;
	logic [5:0]      second_q;
	logic [5:0]      minute_q;
	logic [4:0]      hour_q;
	logic [OP_W-1:0] op_b;
	logic            leap;
	csub_res_t       cs;

	assign leap = (year_q[1:0] == 2'd0);

	always_comb begin
		case (state_q)
			ST_DAYS: op_b = DAY_SECS << k_q;
			ST_HOUR: op_b = HOUR_SECS << k_q;
			ST_MIN:  op_b = MIN_SECS << k_q;
			ST_QUAD: op_b = QUAD_DAYS << k_q;
			ST_YEAR: op_b = {24'd0, year_days(year_q)};
			ST_MON:  op_b = {28'd0, month_days(mon_q, leap)};
			default: op_b = '0;
		endcase
	end

	ecd_csub u_csub (
		.a   (rem_q),
		.b   (op_b),
		.res (cs)
	);

	assign rem_nx = cs.ge ? cs.diff : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (start) state_nx = ST_DAYS;
			ST_DAYS: if (k_q == 4'd0) state_nx = ST_HOUR;
			ST_HOUR: if (k_q == 4'd0) state_nx = ST_MIN;
			ST_MIN:  if (k_q == 4'd0) state_nx = ST_QUAD;
			ST_QUAD: if (k_q == 4'd0) state_nx = ST_YEAR;
			ST_YEAR: if (!cs.ge) state_nx = ST_MON;
			ST_MON:  if (mon_q == LAST_MON || !cs.ge) state_nx = ST_DONE;
			ST_DONE: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					rem_q <= {epoch_seconds[31], epoch_seconds} + EPOCH_BIAS;
					quo_q <= '0;
					k_q   <= 4'd15;
				end
			end
			ST_DAYS: begin
				rem_q <= rem_nx;
				if (k_q == 4'd0) begin
					day_q <= {quo_q[15:1], cs.ge};
					quo_q <= '0;
					k_q   <= 4'd4;
				end else begin
					quo_q[k_q] <= cs.ge;
					k_q        <= k_q - 4'd1;
				end
			end
			ST_HOUR: begin
				rem_q <= rem_nx;
				if (k_q == 4'd0) begin
					hour_q <= {quo_q[4:1], cs.ge};
					quo_q  <= '0;
					k_q    <= 4'd5;
				end else begin
					quo_q[k_q] <= cs.ge;
					k_q        <= k_q - 4'd1;
				end
			end
			ST_MIN: begin
				if (k_q == 4'd0) begin
					minute_q <= {quo_q[5:1], cs.ge};
					second_q <= rem_nx[5:0];
					rem_q    <= {17'd0, day_q};
					quo_q    <= '0;
					k_q      <= 4'd5;
				end else begin
					rem_q      <= rem_nx;
					quo_q[k_q] <= cs.ge;
					k_q        <= k_q - 4'd1;
				end
			end
			ST_QUAD: begin
				rem_q <= rem_nx;
				if (k_q == 4'd0) begin
					year_q <= BASE_YOFF + {quo_q[5:1], cs.ge, 2'b00};
				end else begin
					quo_q[k_q] <= cs.ge;
					k_q        <= k_q - 4'd1;
				end
			end
			ST_YEAR: begin
				if (cs.ge) begin
					rem_q  <= cs.diff;
					year_q <= year_q + 8'd1;
				end else begin
					mon_q <= 4'd0;
				end
			end
			ST_MON: begin
				if (mon_q != LAST_MON && cs.ge) begin
					rem_q <= cs.diff;
					mon_q <= mon_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = (state_q == ST_DONE);
	assign second       = second_q;
	assign minute       = minute_q;
	assign hour         = hour_q;
	assign day_of_month = rem_q[4:0] + 5'd1;
	assign month        = mon_q + 4'd1;
	assign year_offset  = year_q;

endmodule

// File: hw/rtl/ecd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_checker: port level checks of the calendar date converter
// Watches the command handshake and the ranges of each result beat.
// ----------------------------------------------------------------------------
module ecd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [5:0]  second,
	input logic [5:0]  minute,
	input logic [4:0]  hour,
	input logic [4:0]  day_of_month,
	input logic [3:0]  month,
	input logic [7:0]  year_offset
);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !done && !busy)
		else $error("result strobe longer than one cycle or busy held");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result beat");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> second <= 6'd59 && minute <= 6'd59 && hour <= 5'd23
			&& day_of_month != 5'd0 && month != 4'd0 && month <= 4'd12
			&& year_offset != 8'd0 && year_offset <= 8'd138)
		else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar_date ecd_checker u_ecd_checker (.*);
